// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, sampled on the rising clock edge outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/swr_pkg.sv =====
// Types and constants of the sliding window receiver
`timescale 1ns / 1ps

package swr_pkg;

  localparam int SEQ_W       = 8;
  localparam int LEN_W       = 11;
  localparam int WIN_W       = 6;
  localparam int CFG_W       = 11;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH  = 4;

  localparam logic [WIN_W-1:0] WIN_RST = WIN_W'(8);
  localparam logic [LEN_W-1:0] BLK_RST = LEN_W'(1024);

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_BLOCK_SIZE  = 1'b1
  } cfg_reg_e;

  // One ACK run handed from the front end to the back end
  typedef struct packed {
    logic [SEQ_W-1:0] ack_seq;
    logic             oow;
    logic             endf;
    logic [CNT_W-1:0] count;
  } swr_cmd_t;

endpackage

// ===== rtl/swr_mod_unit.sv =====
// Shift-and-subtract remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps

module swr_mod_unit import swr_pkg::*; #(
  parameter int SPACE_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SEQ_W-1:0]   dividend_i,
  input  logic [SPACE_W-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [SEQ_W-1:0]   rem_o
);

  localparam int STEP_W  = $clog2(SEQ_W);
  localparam int TRIAL_W = SEQ_W + SPACE_W;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [SEQ_W-1:0]  rem_q;
  logic [TRIAL_W-1:0] trial;
  logic               fits;

  always_comb begin
    trial = TRIAL_W'(divisor_i) << (STEP_W'(SEQ_W - 1) - step_q);
    fits  = TRIAL_W'(rem_q) >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(SEQ_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
    end else if (busy_q && fits) begin
      rem_q <= rem_q - trial[SEQ_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/swr_front.sv =====
// Front end: config registers, window state and packet classification
`timescale 1ns / 1ps

module swr_front import swr_pkg::*; #(
  parameter int MAX_WINDOW    = 63,
  parameter int SEQ_RATIO     = 2,
  parameter int END_ACK_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             push_i,
  output logic             full_o,
  input  logic [SEQ_W-1:0] seq_num_i,
  input  logic [LEN_W-1:0] payload_length_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output swr_cmd_t         q_cmd_o
);

  localparam int SPACE_W = $clog2(SEQ_RATIO * MAX_WINDOW + 1);
  localparam int SUM_W   = SPACE_W + 1;
  localparam int END_CNT = (END_ACK_COUNT > MAX_RESULTS) ? MAX_RESULTS : END_ACK_COUNT;
  localparam logic [WIN_W-1:0] RST_LAST =
    WIN_W'(((MAX_WINDOW < 8) ? MAX_WINDOW : 8) - 1);

  function automatic logic [WIN_W-1:0] eff_win(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    r = w;
    if (w == '0) r = WIN_W'(1);
    if (w > WIN_W'(MAX_WINDOW)) r = WIN_W'(MAX_WINDOW);
    return r;
  endfunction

  logic [WIN_W-1:0]      win_q;
  logic [LEN_W-1:0]      blk_q;
  logic [SEQ_W-1:0]      base_q;
  logic [SPACE_W-1:0]    res_q;
  logic [MAX_WINDOW-1:0] map_q;
  logic [WIN_W-1:0]      last_q;
  logic                  end_q, fin_q;

  logic                  mod_start, mod_busy, mod_done;
  logic [SEQ_W-1:0]      mod_rem;

  logic [WIN_W-1:0]      ws, off, last_new, last_eff;
  logic [SPACE_W-1:0]    space, res_next;
  logic [SUM_W-1:0]      res_sum;
  logic [SEQ_W:0]        hi;
  logic                  oow, short_pkt, endf, complete, accept, work;
  logic [MAX_WINDOW-1:0] map_new;
  logic [SEQ_W-1:0]      ack_oow, ack_done;

  always_comb begin
    ws        = eff_win(win_q);
    space     = SPACE_W'(ws) * SPACE_W'(SEQ_RATIO);
    hi        = {1'b0, base_q} + (SEQ_W + 1)'(ws);
    oow       = (seq_num_i < base_q) || ({1'b0, seq_num_i} >= hi);
    off       = WIN_W'(seq_num_i - base_q);
    short_pkt = payload_length_i != blk_q;
    last_new  = short_pkt ? off : last_q;
    last_eff  = (last_new < ws) ? last_new : ws - 1'b1;
    endf      = end_q | short_pkt;
    complete  = 1'b1;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      map_new[i] = map_q[i] | (off == WIN_W'(i));
      if (!(map_new[i] || (WIN_W'(i) > last_eff))) complete = 1'b0;
    end
    ack_done = base_q + SEQ_W'(last_eff);
    ack_oow  = (res_q == '0) ? SEQ_W'(space - 1'b1) : SEQ_W'(res_q - 1'b1);
    res_sum  = {1'b0, res_q} + SUM_W'(ws);
    res_next = (res_sum >= SUM_W'(space)) ? SPACE_W'(res_sum - SUM_W'(space))
                                          : SPACE_W'(res_sum);
  end

  // Hold the input while the queue is full or until the new base residue has landed in res_q
  assign full_o    = q_full_i | mod_busy | mod_done;
  assign accept    = push_i & ~full_o;
  assign work      = accept & ~fin_q;
  assign mod_start = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_WINDOW_SIZE);

  // Hand a run to the back end: one word for a stray packet or a completed window, a full run at end of file
  always_comb begin
    q_push_o = work & (oow | complete);
    if (oow) begin
      q_cmd_o = '{ack_seq: ack_oow, oow: 1'b1, endf: 1'b0, count: CNT_W'(1)};
    end else begin
      q_cmd_o = '{ack_seq: ack_done, oow: 1'b0, endf: endf,
                  count: endf ? CNT_W'(END_CNT) : CNT_W'(1)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= WIN_RST;
      blk_q  <= BLK_RST;
      base_q <= '0;
      res_q  <= '0;
      map_q  <= '0;
      last_q <= RST_LAST;
      end_q  <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_WINDOW_SIZE: begin
            win_q <= cfg_data_i[WIN_W-1:0];
            if (!end_q) last_q <= eff_win(cfg_data_i[WIN_W-1:0]) - 1'b1;
          end
          REG_BLOCK_SIZE: blk_q <= cfg_data_i[LEN_W-1:0];
        endcase
      end
      if (mod_done) res_q <= mod_rem[SPACE_W-1:0];
      if (work && !oow) begin
        if (complete) begin
          base_q <= SEQ_W'(res_next);
          res_q  <= res_next;
          map_q  <= '0;
          last_q <= ws - 1'b1;
          if (endf) begin
            fin_q <= 1'b1;
            end_q <= 1'b0;
          end else begin
            end_q <= endf;
          end
        end else begin
          map_q  <= map_new;
          last_q <= last_new;
          end_q  <= endf;
        end
      end
    end
  end

  swr_mod_unit #(
    .SPACE_W (SPACE_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (base_q),
    .divisor_i  (space),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

endmodule

// ===== rtl/swr_fifo.sv =====
// Short command queue between front and back end
`timescale 1ns / 1ps

module swr_fifo import swr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  swr_cmd_t cmd_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output swr_cmd_t head_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W2 = $clog2(FIFO_DEPTH + 1);

  swr_cmd_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W2-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CNT_W2'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

// ===== rtl/swr_back.sv =====
// Back end: expand each run into ACK words behind an output register
`timescale 1ns / 1ps

module swr_back import swr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  swr_cmd_t         q_head_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [SEQ_W-1:0] ack_seq_o,
  output logic             out_of_window_o,
  output logic             window_done_o,
  output logic             transfer_end_o,
  output logic             last_of_run_o
);

  logic             valid_q, oow_q, endf_q, last_q;
  logic [SEQ_W-1:0] ack_q;
  logic [CNT_W-1:0] rem_q;
  logic             advance, more;

  assign advance = ~valid_q | pop_i;
  assign more    = rem_q != '0;
  assign q_pop_o = advance & ~more & ~q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else if (advance) begin
      if (more) begin
        rem_q <= rem_q - 1'b1;
      end else if (!q_empty_i) begin
        valid_q <= 1'b1;
        rem_q   <= q_head_i.count - 1'b1;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (more) begin
        last_q <= rem_q == CNT_W'(1);
      end else if (!q_empty_i) begin
        ack_q  <= q_head_i.ack_seq;
        oow_q  <= q_head_i.oow;
        endf_q <= q_head_i.endf;
        last_q <= q_head_i.count == CNT_W'(1);
      end
    end
  end

  assign empty_o         = ~valid_q;
  assign ack_seq_o       = ack_q;
  assign out_of_window_o = oow_q;
  assign window_done_o   = ~oow_q;
  assign transfer_end_o  = endf_q;
  assign last_of_run_o   = last_q;

endmodule

// ===== rtl/sliding_window_receiver_ack.sv =====
// The first ACK word of a packet passes the command queue and the output register.
// Throughput: one packet per cycle while full is low; a completed end-of-file window yields
// END_ACK_COUNT words (at most 8), one per cycle while pop is held, from the back end while
// the front keeps taking packets. A window_size write recomputes the base residue in the
// shift-subtract unit; full stays high until it is stored. Reset is asynchronous, active
// low: window 8, block 1024, base 0, bitmap clear, queue and output register empty.
`timescale 1ns / 1ps

module sliding_window_receiver_ack import swr_pkg::*; #(
  parameter int MAX_WINDOW    = 63,
  parameter int SEQ_RATIO     = 2,
  parameter int END_ACK_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // packet side
  input  logic             push,
  output logic             full,
  input  logic [SEQ_W-1:0] seq_num_i,
  input  logic [LEN_W-1:0] payload_length_i,
  // ACK side
  output logic             empty,
  input  logic             pop,
  output logic [SEQ_W-1:0] ack_seq_o,
  output logic             out_of_window_o,
  output logic             window_done_o,
  output logic             transfer_end_o,
  output logic             last_of_run_o
);

  // Command queue between the two halves: the front classifies a packet and
  // updates the window in the cycle it is taken, the back expands runs.
  swr_cmd_t push_cmd, head_cmd;
  logic     q_push, q_pop, q_full, q_empty;

  // Front: hold config, window base, bitmap and end flag; drop packets after the end
  swr_front #(
    .MAX_WINDOW    (MAX_WINDOW),
    .SEQ_RATIO     (SEQ_RATIO),
    .END_ACK_COUNT (END_ACK_COUNT)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push_i           (push),
    .full_o           (full),
    .seq_num_i        (seq_num_i),
    .payload_length_i (payload_length_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (push_cmd)
  );

  // Queue: absorb end-of-file runs so the front need not wait for the ACK side
  swr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_cmd)
  );

  // Back: advance one ACK word per pop, keep the last word held while stalled
  swr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_head_i        (head_cmd),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .ack_seq_o       (ack_seq_o),
    .out_of_window_o (out_of_window_o),
    .window_done_o   (window_done_o),
    .transfer_end_o  (transfer_end_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ===== rtl/swr_checker.sv =====
// Port-level checker for the sliding window receiver, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swr_checker import swr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic [SEQ_W-1:0] ack_seq_o,
  input logic             out_of_window_o,
  input logic             window_done_o,
  input logic             transfer_end_o,
  input logic             last_of_run_o
);

  `ASSERT_NEXT(a_word_holds, !empty && !pop, !empty && $stable(ack_seq_o))
  `ASSERT_IMPL(a_kind_excl, !empty, out_of_window_o != window_done_o)
  `ASSERT_IMPL(a_oow_single, !empty && out_of_window_o, last_of_run_o && !transfer_end_o)
  `ASSERT_NEXT(a_run_continues, !empty && pop && !last_of_run_o, !empty && transfer_end_o)
  `ASSERT_NEXT(a_run_same_seq, !empty && pop && !last_of_run_o, $stable(ack_seq_o))

endmodule

bind sliding_window_receiver_ack swr_checker u_swr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .ack_seq_o       (ack_seq_o),
  .out_of_window_o (out_of_window_o),
  .window_done_o   (window_done_o),
  .transfer_end_o  (transfer_end_o),
  .last_of_run_o   (last_of_run_o)
);
